[rtl/clpe_pkg.sv]
// ----------------------------------------------------------------------------
// Pair energy engine package
// Shared payload types, command and status codes, sequencer operations and
// the control and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package clpe_pkg;

   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_PAIR  = 2'd1;
   localparam logic [1:0] CMD_CLOSE = 2'd2;
   localparam logic [1:0] CMD_NONE  = 2'd3;

   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_ZERO_DIST = 2'd1;
   localparam logic [1:0] STAT_NEG_EPS   = 2'd2;
   localparam logic [1:0] STAT_SAT       = 2'd3;

   // 332.063711 in Q.16, rounded.
   localparam logic [24:0] COULOMB_Q16 = 25'd21762127;
   localparam logic [63:0] COUL_CAP    = 64'h2000_0000_0000_0000;
   localparam logic [63:0] LJ_CAP      = 64'h4000_0000_0000_0000;
   localparam logic signed [47:0] E_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] E_MIN = 48'sh8000_0000_0000;

   typedef struct packed {
      logic [1:0]         command;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [15:0] charge;
      logic signed [15:0] well_depth;
      logic [15:0]        half_rmin;
   } req_item_type;

   typedef struct packed {
      logic signed [47:0] pair_energy;
      logic signed [47:0] running_total;
      logic               total_closed;
      logic [1:0]         status;
   } rsp_item_type;

   typedef enum logic [3:0] {
      OP_SQX, OP_SQY, OP_SQZ, OP_COULMUL, OP_COULDIV, OP_SQRT, OP_RSQ,
      OP_TDIV, OP_T2, OP_R6, OP_R12, OP_LJ, OP_FINAL
   } op_type;

   typedef enum logic [1:0] {CS_IDLE, CS_START, CS_WAIT} ctrl_state_type;

   typedef struct packed {
      logic   capture;
      op_type op;
      logic   start;
      logic   finish;
   } dp_cmd_type;

   typedef struct packed {
      logic req_is_pair;
      logic unit_done;
      logic zero_dist;
      logic dist_big;
      logic eps_pos;
      logic ratio_big;
      logic out_free;
   } dp_stat_type;

endpackage

[rtl/clpe_mul.sv]
// ----------------------------------------------------------------------------
// Iterative multiplier
// 64 x 64 unsigned product, eight multiplier bits per cycle.
// ----------------------------------------------------------------------------
module clpe_mul (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [63:0]  mul_a,
   input  logic [63:0]  mul_b,
   output logic         done,
   output logic [127:0] product
);

   logic [127:0] a_ff, a_in;
   logic [63:0]  b_ff, b_in;
   logic [127:0] prod_ff, prod_in;
   logic [2:0]   cnt_ff, cnt_in;
   logic         busy_ff, busy_in;
   logic         done_ff, done_in;

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      prod_in = prod_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = {64'd0, mul_a};
         b_in    = mul_b;
         prod_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         prod_in = prod_ff + (a_ff * {120'd0, b_ff[7:0]});
         a_in    = {a_ff[119:0], 8'd0};
         b_in    = {8'd0, b_ff[63:8]};
         cnt_in  = cnt_ff + 3'd1;
         if (cnt_ff == 3'd7) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      prod_ff <= prod_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done    = done_ff;
   assign product = prod_ff;

endmodule

[rtl/clpe_div.sv]
// ----------------------------------------------------------------------------
// Iterative divider
// 64 / 64 unsigned restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module clpe_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [63:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);

   logic [63:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [63:0] den_ff, den_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [64:0] shifted;
   logic [64:0] diff;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quo_ff[63]};
      diff    = shifted - {1'b0, den_ff};
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[64]) begin
            rem_in = diff[63:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = shifted[63:0];
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[rtl/clpe_sqrt.sv]
// ----------------------------------------------------------------------------
// Iterative square root
// Floor square root of a 40-bit value, one root bit per cycle.
// ----------------------------------------------------------------------------
module clpe_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [39:0] radicand,
   output logic        done,
   output logic [19:0] root
);

   logic [39:0] rad_ff, rad_in;
   logic [21:0] rem_ff, rem_in;
   logic [19:0] root_ff, root_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [23:0] rem_next;
   logic [23:0] trial;

   always_comb begin
      rad_in   = rad_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      rem_next = {rem_ff, rad_ff[39:38]};
      trial    = {2'b00, root_ff, 2'b01};
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[37:0], 2'b00};
         if (rem_next >= trial) begin
            rem_in  = 22'(rem_next - trial);
            root_in = {root_ff[18:0], 1'b1};
         end else begin
            rem_in  = rem_next[21:0];
            root_in = {root_ff[18:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd19) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

[rtl/clpe_ctrl.sv]
// ----------------------------------------------------------------------------
// Pair energy sequencer
// Walks the operation list for one pair, skips operations that cannot change
// the result and waits on the shared arithmetic units.
// ----------------------------------------------------------------------------
module clpe_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  clpe_pkg::dp_stat_type stat,
   output clpe_pkg::dp_cmd_type  cmd
);

   clpe_pkg::ctrl_state_type state_ff, state_in;
   clpe_pkg::op_type         op_ff, op_in;
   logic                     skip;
   clpe_pkg::op_type         succ;

   always_comb begin
      unique case (op_ff)
         clpe_pkg::OP_SQX:     succ = clpe_pkg::OP_SQY;
         clpe_pkg::OP_SQY:     succ = clpe_pkg::OP_SQZ;
         clpe_pkg::OP_SQZ:     succ = clpe_pkg::OP_COULMUL;
         clpe_pkg::OP_COULMUL: succ = clpe_pkg::OP_COULDIV;
         clpe_pkg::OP_COULDIV: succ = clpe_pkg::OP_SQRT;
         clpe_pkg::OP_SQRT:    succ = clpe_pkg::OP_RSQ;
         clpe_pkg::OP_RSQ:     succ = clpe_pkg::OP_TDIV;
         clpe_pkg::OP_TDIV:    succ = clpe_pkg::OP_T2;
         clpe_pkg::OP_T2:      succ = clpe_pkg::OP_R6;
         clpe_pkg::OP_R6:      succ = clpe_pkg::OP_R12;
         clpe_pkg::OP_R12:     succ = clpe_pkg::OP_LJ;
         default:              succ = clpe_pkg::OP_FINAL;
      endcase

      // An operation is skipped when its result cannot reach the output.
      unique case (op_ff)
         clpe_pkg::OP_COULMUL: skip = stat.zero_dist;
         clpe_pkg::OP_COULDIV: skip = stat.zero_dist | stat.dist_big;
         clpe_pkg::OP_SQRT,
         clpe_pkg::OP_RSQ:     skip = stat.zero_dist | ~stat.eps_pos;
         clpe_pkg::OP_TDIV:    skip = stat.zero_dist | ~stat.eps_pos | stat.dist_big;
         clpe_pkg::OP_T2,
         clpe_pkg::OP_R6,
         clpe_pkg::OP_R12,
         clpe_pkg::OP_LJ:      skip = stat.zero_dist | ~stat.eps_pos | stat.ratio_big;
         default:              skip = 1'b0;
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      cmd.capture = 1'b0;
      cmd.op      = op_ff;
      cmd.start   = 1'b0;
      cmd.finish  = 1'b0;
      req_ready   = 1'b0;
      unique case (state_ff)
         clpe_pkg::CS_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (stat.req_is_pair) begin
                  op_in    = clpe_pkg::OP_SQX;
                  state_in = clpe_pkg::CS_START;
               end
            end
         end
         clpe_pkg::CS_START: begin
            priority if (skip) begin
               op_in = succ;
            end else if (op_ff == clpe_pkg::OP_FINAL) begin
               if (stat.out_free) begin
                  cmd.finish = 1'b1;
                  state_in   = clpe_pkg::CS_IDLE;
               end
            end else begin
               cmd.start = 1'b1;
               state_in  = clpe_pkg::CS_WAIT;
            end
         end
         clpe_pkg::CS_WAIT: begin
            if (stat.unit_done) begin
               op_in    = succ;
               state_in = clpe_pkg::CS_START;
            end
         end
         default: state_in = clpe_pkg::CS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= clpe_pkg::CS_IDLE;
         op_ff    <= clpe_pkg::OP_SQX;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

endmodule

[rtl/clpe_dp.sv]
// ----------------------------------------------------------------------------
// Pair energy datapath
// Anchor registers, intermediate terms, the shared multiplier, divider and
// square root units, the energy sum and the result register.
// ----------------------------------------------------------------------------
module clpe_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  clpe_pkg::req_item_type req_payload,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output clpe_pkg::rsp_item_type rsp_payload,
   input  clpe_pkg::dp_cmd_type   cmd,
   output clpe_pkg::dp_stat_type  stat
);

   // Anchor atom
   logic signed [31:0] anc_x_ff, anc_y_ff, anc_z_ff;
   logic signed [15:0] anc_q_ff, anc_eps_ff;
   logic [15:0]        anc_hr_ff;
   logic signed [47:0] energy_sum_ff;

   // Current pair
   clpe_pkg::req_item_type in_ff;
   logic               p_neg_ff;
   logic [30:0]        p_mag_ff;
   logic signed [31:0] ep_ff;
   logic [16:0]        rs_ff;
   logic [65:0]        s_ff;
   logic [55:0]        cnum_ff;
   logic [63:0]        c_ff;
   logic [19:0]        eq_ff;
   logic [33:0]        rs2_ff;
   logic [63:0]        t_ff;
   logic [31:0]        t2_ff;
   logic [39:0]        r6_ff;
   logic [63:0]        r12_ff;
   logic signed [63:0] lj_ff;

   logic                  rsp_valid_ff;
   clpe_pkg::rsp_item_type rsp_ff;

   logic signed [31:0] p_prod, ep_prod;
   logic signed [32:0] dx, dy, dz;
   logic [32:0]        ax, ay, az;

   logic [63:0]  mul_a, mul_b, div_num;
   logic         mul_start, div_start, sqrt_start;
   logic         mul_done, div_done, sqrt_done;
   logic [127:0] mul_product;
   logic [63:0]  div_quo;
   logic [19:0]  sqrt_root;

   logic [63:0] two6;
   logic        lj_neg;
   logic [63:0] lj_mag;
   logic [62:0] lj_m;

   logic               close;
   logic               zero_dist, neg_eps;
   logic [61:0]        c_sat;
   logic signed [63:0] coul_val, lj_val;
   logic signed [64:0] sum_wide;
   logic signed [47:0] pair_val, total_val;
   logic signed [48:0] tot_wide;
   logic               sat_pair, sat_tot;
   logic [1:0]         status_val;

   assign p_prod  = anc_q_ff * req_payload.charge;
   assign ep_prod = anc_eps_ff * req_payload.well_depth;

   assign dx = 33'(in_ff.pos_x) - 33'(anc_x_ff);
   assign dy = 33'(in_ff.pos_y) - 33'(anc_y_ff);
   assign dz = 33'(in_ff.pos_z) - 33'(anc_z_ff);
   assign ax = dx[32] ? 33'(-dx) : 33'(dx);
   assign ay = dy[32] ? 33'(-dy) : 33'(dy);
   assign az = dz[32] ? 33'(-dz) : 33'(dz);

   assign two6   = {23'd0, r6_ff, 1'b0};
   assign lj_neg = r12_ff < two6;
   assign lj_mag = lj_neg ? (two6 - r12_ff) : (r12_ff - two6);
   assign lj_m   = (mul_product[127:16] > 112'(clpe_pkg::LJ_CAP))
                   ? clpe_pkg::LJ_CAP[62:0] : mul_product[78:16];

   always_comb begin
      mul_a     = '0;
      mul_b     = '0;
      mul_start = 1'b0;
      div_num   = '0;
      div_start = 1'b0;
      sqrt_start = 1'b0;
      unique case (cmd.op)
         clpe_pkg::OP_SQX: begin
            mul_a = {31'd0, ax};
            mul_b = {31'd0, ax};
            mul_start = cmd.start;
         end
         clpe_pkg::OP_SQY: begin
            mul_a = {31'd0, ay};
            mul_b = {31'd0, ay};
            mul_start = cmd.start;
         end
         clpe_pkg::OP_SQZ: begin
            mul_a = {31'd0, az};
            mul_b = {31'd0, az};
            mul_start = cmd.start;
         end
         clpe_pkg::OP_COULMUL: begin
            mul_a = {39'd0, clpe_pkg::COULOMB_Q16};
            mul_b = {33'd0, p_mag_ff};
            mul_start = cmd.start;
         end
         clpe_pkg::OP_COULDIV: begin
            div_num   = {cnum_ff, 8'd0};
            div_start = cmd.start;
         end
         clpe_pkg::OP_SQRT: begin
            sqrt_start = cmd.start;
         end
         clpe_pkg::OP_RSQ: begin
            mul_a = {47'd0, rs_ff};
            mul_b = {47'd0, rs_ff};
            mul_start = cmd.start;
         end
         clpe_pkg::OP_TDIV: begin
            div_num   = {6'd0, rs2_ff, 24'd0};
            div_start = cmd.start;
         end
         clpe_pkg::OP_T2: begin
            mul_a = {40'd0, t_ff[23:0]};
            mul_b = {40'd0, t_ff[23:0]};
            mul_start = cmd.start;
         end
         clpe_pkg::OP_R6: begin
            mul_a = {32'd0, t2_ff};
            mul_b = {40'd0, t_ff[23:0]};
            mul_start = cmd.start;
         end
         clpe_pkg::OP_R12: begin
            mul_a = {24'd0, r6_ff};
            mul_b = {24'd0, r6_ff};
            mul_start = cmd.start;
         end
         clpe_pkg::OP_LJ: begin
            mul_a = {44'd0, eq_ff};
            mul_b = lj_mag;
            mul_start = cmd.start;
         end
         default: ;
      endcase
   end

   clpe_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .done    (mul_done),
      .product (mul_product)
   );

   clpe_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (s_ff[63:0]),
      .done     (div_done),
      .quotient (div_quo)
   );

   clpe_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand ({ep_ff, 8'd0}),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   // Result assembly
   always_comb begin
      close     = (in_ff.command == clpe_pkg::CMD_CLOSE);
      zero_dist = (s_ff == '0);
      neg_eps   = ep_ff < 0;
      c_sat     = (c_ff > clpe_pkg::COUL_CAP) ? clpe_pkg::COUL_CAP[61:0] : c_ff[61:0];
      coul_val  = p_neg_ff ? -$signed({2'b00, c_sat}) : $signed({2'b00, c_sat});
      lj_val    = (t_ff[63:24] != '0) ? $signed(clpe_pkg::LJ_CAP) : lj_ff;
      sum_wide  = 65'(coul_val) + 65'(lj_val);
      sat_pair  = 1'b0;
      if (zero_dist) begin
         pair_val = '0;
      end else if (sum_wide > 65'(clpe_pkg::E_MAX)) begin
         pair_val = clpe_pkg::E_MAX;
         sat_pair = 1'b1;
      end else if (sum_wide < 65'(clpe_pkg::E_MIN)) begin
         pair_val = clpe_pkg::E_MIN;
         sat_pair = 1'b1;
      end else begin
         pair_val = sum_wide[47:0];
      end
      tot_wide = 49'(energy_sum_ff) + 49'(pair_val);
      sat_tot  = 1'b0;
      if (tot_wide > 49'(clpe_pkg::E_MAX)) begin
         total_val = clpe_pkg::E_MAX;
         sat_tot   = 1'b1;
      end else if (tot_wide < 49'(clpe_pkg::E_MIN)) begin
         total_val = clpe_pkg::E_MIN;
         sat_tot   = 1'b1;
      end else begin
         total_val = tot_wide[47:0];
      end
      priority if (zero_dist) begin
         status_val = clpe_pkg::STAT_ZERO_DIST;
      end else if (neg_eps) begin
         status_val = clpe_pkg::STAT_NEG_EPS;
      end else if (sat_pair | sat_tot) begin
         status_val = clpe_pkg::STAT_SAT;
      end else begin
         status_val = clpe_pkg::STAT_OK;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         in_ff    <= req_payload;
         p_neg_ff <= p_prod < 0;
         p_mag_ff <= p_prod[31] ? 31'(-p_prod) : p_prod[30:0];
         ep_ff    <= ep_prod;
         rs_ff    <= {1'b0, anc_hr_ff} + {1'b0, req_payload.half_rmin};
         c_ff     <= '0;
         t_ff     <= '0;
         lj_ff    <= '0;
      end
      if (mul_done) begin
         unique case (cmd.op)
            clpe_pkg::OP_SQX:     s_ff    <= mul_product[65:0];
            clpe_pkg::OP_SQY,
            clpe_pkg::OP_SQZ:     s_ff    <= s_ff + mul_product[65:0];
            clpe_pkg::OP_COULMUL: cnum_ff <= mul_product[55:0];
            clpe_pkg::OP_RSQ:     rs2_ff  <= mul_product[33:0];
            clpe_pkg::OP_T2:      t2_ff   <= mul_product[47:16];
            clpe_pkg::OP_R6:      r6_ff   <= mul_product[55:16];
            clpe_pkg::OP_R12:     r12_ff  <= mul_product[79:16];
            clpe_pkg::OP_LJ:
               lj_ff <= lj_neg ? -$signed({1'b0, lj_m}) : $signed({1'b0, lj_m});
            default: ;
         endcase
      end
      if (div_done) begin
         if (cmd.op == clpe_pkg::OP_COULDIV) begin
            c_ff <= div_quo;
         end else begin
            t_ff <= div_quo;
         end
      end
      if (sqrt_done) begin
         eq_ff <= sqrt_root;
      end
      if (cmd.finish) begin
         rsp_ff.pair_energy   <= pair_val;
         rsp_ff.running_total <= total_val;
         rsp_ff.total_closed  <= close;
         rsp_ff.status        <= status_val;
      end
   end

   // Architectural state and output handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         anc_x_ff      <= '0;
         anc_y_ff      <= '0;
         anc_z_ff      <= '0;
         anc_q_ff      <= '0;
         anc_eps_ff    <= '0;
         anc_hr_ff     <= '0;
         energy_sum_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.capture && req_payload.command == clpe_pkg::CMD_LOAD) begin
            anc_x_ff   <= req_payload.pos_x;
            anc_y_ff   <= req_payload.pos_y;
            anc_z_ff   <= req_payload.pos_z;
            anc_q_ff   <= req_payload.charge;
            anc_eps_ff <= req_payload.well_depth;
            anc_hr_ff  <= req_payload.half_rmin;
         end
         if (cmd.finish) begin
            energy_sum_ff <= close ? '0 : total_val;
            rsp_valid_ff  <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign stat.req_is_pair = (req_payload.command == clpe_pkg::CMD_PAIR) ||
                             (req_payload.command == clpe_pkg::CMD_CLOSE);
   assign stat.unit_done   = mul_done | div_done | sqrt_done;
   assign stat.zero_dist   = zero_dist;
   assign stat.dist_big    = (s_ff[65:64] != 2'b00);
   assign stat.eps_pos     = ep_ff > 0;
   assign stat.ratio_big   = (t_ff[63:24] != '0);
   assign stat.out_free    = ~rsp_valid_ff | rsp_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

[rtl/coulomb_lj_pair_energy_unit.sv]
// ----------------------------------------------------------------------------
// Lennard-Jones 12-6 plus Coulomb pair energy unit
// Takes one command at a time and returns one result per pair or close command.
// ----------------------------------------------------------------------------
// A load command gives no result; command 3 is dropped. A pair command runs
// through a sequencer that shares one multiplier, one radix-2 divider and one
// square root unit: a full pair spends its time mostly in the two divisions
// (Coulomb term and (R1+R2)^2/d^2); a pair at zero distance or with a
// non-positive epsilon product skips the operations that cannot change its
// result. A finished result waits in an output register, so the next command
// is taken while it is still unclaimed.
module coulomb_lj_pair_energy_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  clpe_pkg::req_item_type req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output clpe_pkg::rsp_item_type rsp_payload
);

   clpe_pkg::dp_cmd_type  cmd;
   clpe_pkg::dp_stat_type stat;

   clpe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   clpe_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .stat        (stat)
   );

endmodule

[rtl/clpe_checker.sv]
// ----------------------------------------------------------------------------
// Pair energy port checker
// Watches the top-level ports for handshake slips and result consistency.
// ----------------------------------------------------------------------------
module clpe_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input clpe_pkg::req_item_type req_payload,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input clpe_pkg::rsp_item_type rsp_payload
);

   // Set while the energy sum is known to be zero: after reset and after a
   // closing result has been transferred.
   logic fresh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fresh_ff <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
         fresh_ff <= rsp_payload.total_closed;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result present after reset");

   a_zero_dist: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == clpe_pkg::STAT_ZERO_DIST
      |-> rsp_payload.pair_energy == '0)
      else $error("nonzero energy at zero distance");

   a_fresh_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && fresh_ff |-> rsp_payload.running_total == rsp_payload.pair_energy)
      else $error("running total not restarted");

endmodule

bind coulomb_lj_pair_energy_unit clpe_checker u_clpe_checker (.*);

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// Pair energy unit testbench
// Drives load, pair, close and unused commands into the unit under random
// idling and back-pressure, predicts each pair result with a fixed-point
// energy model and compares every result field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   clpe_pkg::req_item_type req_payload;
   logic                   rsp_valid;
   logic                   rsp_ready;
   clpe_pkg::rsp_item_type rsp_payload;

   coulomb_lj_pair_energy_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload)
   );

   clpe_pkg::req_item_type pending_cmds[$];
   clpe_pkg::rsp_item_type expected_energies[$];

   // Anchor atom and running sum as seen by the predictor.
   logic signed [31:0] atom_x, atom_y, atom_z;
   logic signed [15:0] atom_q, atom_eps;
   logic [15:0]        atom_rhalf;
   logic signed [47:0] sum_energy;

   int  send_idle_pct, recv_stall_pct;
   int  hold_off_cycles;
   bit  hold_off_arm, hold_off_used;
   int  errors;
   longint cycle_count;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [63:0] isqrt(logic [63:0] v);
      logic [63:0] res, bit_v;
      res = 0;
      bit_v = 64'h4000_0000_0000_0000;
      while (bit_v > v) bit_v = bit_v >> 2;
      while (bit_v != 0) begin
         if (v >= res + bit_v) begin
            v = v - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return res;
   endfunction

   function automatic logic [63:0] mul16_cap(logic [63:0] a, logic [63:0] b,
                                             logic [63:0] cap);
      logic [127:0] p;
      p = (a * 128'd1) * b;
      p = p >> 16;
      if (p[127:64] != 0) return cap;
      return (p[63:0] > cap) ? cap : p[63:0];
   endfunction

   function automatic logic signed [47:0] clamp_energy(logic signed [67:0] v,
                                                       inout bit sat);
      if (v > 68'sh7FFF_FFFF_FFFF) begin
         sat = 1;
         return clpe_pkg::E_MAX;
      end
      if (v < -68'sh8000_0000_0000) begin
         sat = 1;
         return clpe_pkg::E_MIN;
      end
      return v[47:0];
   endfunction

   task automatic enqueue_cmd(input clpe_pkg::req_item_type c);
      pending_cmds.insert(pending_cmds.size(), c);
   endtask

   // Applies one accepted command to the predictor state and queues the result of a pair or close command.
   task automatic predict_energy(input clpe_pkg::req_item_type it);
      logic signed [65:0]  dx, dy, dz;
      logic [65:0]         dsq;
      logic signed [31:0]  qq, ee;
      logic [31:0]         uq;
      logic [127:0]        num;
      logic [63:0]         coul_mag, eq, t, t2, r6, r12, two6, mag, m;
      logic [16:0]         rs;
      logic signed [67:0]  coul, lj;
      logic signed [47:0]  pair_e, total;
      bit                  sat, neg_eps, zero_d, neg;
      clpe_pkg::rsp_item_type r;
      sat = 0; neg_eps = 0; pair_e = 0;
      if (it.command == clpe_pkg::CMD_LOAD) begin
         atom_x = it.pos_x; atom_y = it.pos_y; atom_z = it.pos_z;
         atom_q = it.charge; atom_eps = it.well_depth; atom_rhalf = it.half_rmin;
         return;
      end
      if (it.command == clpe_pkg::CMD_NONE) return;
      dx = it.pos_x - atom_x;
      dy = it.pos_y - atom_y;
      dz = it.pos_z - atom_z;
      dsq = dx * dx + dy * dy + dz * dz;
      zero_d = (dsq == 0);
      if (!zero_d) begin
         qq = atom_q * it.charge;
         uq = (qq < 0) ? -qq : qq;
         if (dsq[65:64] != 0) begin
            coul_mag = 0;
         end else begin
            num = (128'(clpe_pkg::COULOMB_Q16) * uq) << 8;
            num = num / dsq[63:0];
            coul_mag = num[63:0];
         end
         if (coul_mag > clpe_pkg::COUL_CAP) coul_mag = clpe_pkg::COUL_CAP;
         coul = (qq < 0) ? -$signed({4'b0, coul_mag}) : $signed({4'b0, coul_mag});
         lj = 0;
         ee = atom_eps * it.well_depth;
         if (ee < 0) begin
            neg_eps = 1;
         end else if (ee > 0) begin
            eq = isqrt(64'(ee) << 8);
            rs = atom_rhalf + it.half_rmin;
            if (dsq[65:64] != 0) begin
               t = 0;
            end else begin
               num = (128'(rs) * rs) << 24;
               num = num / dsq[63:0];
               t = num[63:0];
            end
            if (t >= 64'h100_0000) begin
               lj = $signed({4'b0, clpe_pkg::LJ_CAP});
            end else begin
               t2 = (t * t) >> 16;
               r6 = (t2 * t) >> 16;
               r12 = mul16_cap(r6, r6, 64'hFFFF_FFFF_FFFF_FFFF);
               two6 = r6 << 1;
               neg = r12 < two6;
               mag = neg ? two6 - r12 : r12 - two6;
               m = mul16_cap(eq, mag, clpe_pkg::LJ_CAP);
               lj = neg ? -$signed({4'b0, m}) : $signed({4'b0, m});
            end
         end
         pair_e = clamp_energy(coul + lj, sat);
      end
      total = clamp_energy(68'(sum_energy) + 68'(pair_e), sat);
      sum_energy = (it.command == clpe_pkg::CMD_CLOSE) ? 48'sd0 : total;
      r.pair_energy = pair_e;
      r.running_total = total;
      r.total_closed = (it.command == clpe_pkg::CMD_CLOSE);
      r.status = zero_d ? clpe_pkg::STAT_ZERO_DIST : neg_eps ? clpe_pkg::STAT_NEG_EPS :
                 sat ? clpe_pkg::STAT_SAT : clpe_pkg::STAT_OK;
      expected_energies.insert(expected_energies.size(), r);
   endtask

   function automatic clpe_pkg::req_item_type make_atom(logic [1:0] cmd, int span);
      clpe_pkg::req_item_type a;
      a.command = cmd;
      a.pos_x = $signed($urandom_range(0, 2 * span)) - span;
      a.pos_y = $signed($urandom_range(0, 2 * span)) - span;
      a.pos_z = $signed($urandom_range(0, 2 * span)) - span;
      a.charge = $signed(16'($urandom_range(0, 8192))) - 16'sd4096;
      a.well_depth = 16'($urandom_range(0, 2048));
      a.half_rmin = 16'($urandom_range(2048, 10240));
      return a;
   endfunction

   function automatic clpe_pkg::req_item_type noise_atom();
      clpe_pkg::req_item_type a;
      logic [191:0]           raw;
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      a = raw[$bits(clpe_pkg::req_item_type)-1:0];
      a.command = 2'($urandom_range(0, 3));
      return a;
   endfunction

   // Driver: offers the head of the pending queue, holding it until accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) void'(pending_cmds.pop_front());
         if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_payload <= pending_cmds[0];
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Prediction happens at the accepting edge.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) predict_energy(req_payload);
   end

   // Long receiver hold-off, counted down on its own.
   always @(posedge clock) begin
      if (reset) begin
         hold_off_cycles <= 0;
         hold_off_used   <= 1'b0;
      end else if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
      end else if (hold_off_arm && !hold_off_used) begin
         hold_off_cycles <= 3000;
         hold_off_used   <= 1'b1;
      end
   end

   // Receiver ready and result check.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_energies.size() == 0) begin
               $display("%0t: unexpected result %h", $time, rsp_payload);
               errors++;
            end else begin
               clpe_pkg::rsp_item_type e;
               e = expected_energies.pop_front();
               if (e.pair_energy !== rsp_payload.pair_energy ||
                   e.running_total !== rsp_payload.running_total ||
                   e.total_closed !== rsp_payload.total_closed ||
                   e.status !== rsp_payload.status) begin
                  $display("%0t: mismatch expected %h %h %b %0d actual %h %h %b %0d",
                           $time, e.pair_energy, e.running_total, e.total_closed,
                           e.status, rsp_payload.pair_energy,
                           rsp_payload.running_total, rsp_payload.total_closed,
                           rsp_payload.status);
                  errors++;
               end
            end
         end
         if (hold_off_cycles > 0) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 2_000_000) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_cmds.size() != 0 || req_valid || expected_energies.size() != 0)
         @(posedge clock);
   endtask

   task automatic add_sequence();
      int n;
      enqueue_cmd(make_atom(clpe_pkg::CMD_LOAD, 1 << ($urandom_range(14, 20))));
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++)
         enqueue_cmd(make_atom((i == n - 1 && $urandom_range(0, 1)) ?
                               clpe_pkg::CMD_CLOSE : clpe_pkg::CMD_PAIR,
                               1 << ($urandom_range(14, 20))));
   endtask

   initial begin
      clpe_pkg::req_item_type a;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_ready = 1'b0;
      errors = 0; cycle_count = 0; hold_off_arm = 1'b0;
      send_idle_pct = 0; recv_stall_pct = 0;
      atom_x = 0; atom_y = 0; atom_z = 0;
      atom_q = 0; atom_eps = 0; atom_rhalf = 0; sum_energy = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: pair before any load (zero distance), then extremes.
      a = '0; a.command = clpe_pkg::CMD_PAIR; enqueue_cmd(a);
      a.command = clpe_pkg::CMD_CLOSE; a.pos_x = 32'sh0001_0000; enqueue_cmd(a);
      a = '0; a.command = clpe_pkg::CMD_LOAD; a.charge = 16'sh7FFF;
      a.well_depth = 16'sh7FFF; a.half_rmin = 16'hFFFF; enqueue_cmd(a);
      a.command = clpe_pkg::CMD_PAIR; a.pos_x = 32'sh0000_0001; enqueue_cmd(a);
      a.pos_x = 0; enqueue_cmd(a);
      a.pos_x = 32'sh7FFF_FFFF; a.pos_y = 32'sh7FFF_FFFF; a.pos_z = 32'sh7FFF_FFFF;
      enqueue_cmd(a);
      a.pos_x = 32'sh8000_0000; a.pos_y = 32'sh8000_0000; a.pos_z = 32'sh8000_0000;
      a.charge = 16'sh8000; a.well_depth = 16'sh8000; enqueue_cmd(a);
      a.pos_x = 32'sh0004_0000; a.pos_y = 0; a.pos_z = 0; a.well_depth = 0;
      a.charge = 16'sh8000; enqueue_cmd(a);
      a.well_depth = 16'sh1000; a.half_rmin = 0; a.command = clpe_pkg::CMD_NONE;
      enqueue_cmd(a);
      a.command = clpe_pkg::CMD_CLOSE; enqueue_cmd(a);
      a = '0; a.command = clpe_pkg::CMD_LOAD; a.charge = 16'sh8000;
      a.well_depth = 16'sh8000;
      a.pos_x = 32'sh8000_0000; a.pos_y = 32'sh7FFF_FFFF; enqueue_cmd(a);
      a.command = clpe_pkg::CMD_PAIR; a.pos_x = 32'sh7FFF_FFFF; a.pos_y = 32'sh8000_0000;
      a.half_rmin = 16'hFFFF; enqueue_cmd(a);
      a.pos_x = 32'sh8000_1000; a.pos_y = 32'sh7FFF_FFFF; a.well_depth = 16'sh7FFF;
      enqueue_cmd(a);
      // Small distances with a positive product drive the total to saturation.
      for (int i = 0; i < 4; i++) begin
         a.pos_x = 32'sh8000_0001; a.charge = 16'sh8000; a.well_depth = 16'sh8000;
         enqueue_cmd(a);
      end
      a.command = clpe_pkg::CMD_CLOSE; enqueue_cmd(a);
      wait_drained();

      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
            3: begin send_idle_pct = 28; recv_stall_pct = 28; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
         endcase
         if (phase == 4) hold_off_arm = 1'b1;
         while (pending_cmds.size() < 125) begin
            if ($urandom_range(0, 9) < 8) add_sequence();
            else enqueue_cmd(noise_atom());
         end
         wait_drained();
      end
      repeat (400) @(posedge clock);
      if (errors == 0 && expected_energies.size() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end
endmodule
